### hw/rtl/link_setup_set_ua_handshake_defines.svh
// Assertion macros for the link setup handshake block.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef LINK_SETUP_SET_UA_HANDSHAKE_DEFINES_SVH
`define LINK_SETUP_SET_UA_HANDSHAKE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that a condition implies another in the same cycle.
`define LSS_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("lss check failed");
// Check that a condition implies another in the next cycle.
`define LSS_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("lss check failed");
`else
`define LSS_ASSERT_SAME(label, clk, rst_n, a, c)
`define LSS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/lss_pkg.sv
// Shared types, codes and frame constants for the link setup handshake.
// Used by every module of the block; depends on nothing.
`default_nettype none
package lss_pkg;

	// Frame bytes.
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ADDR_BYTE = 8'h03;
	localparam logic [7:0] CTRL_SET  = 8'h03;
	localparam logic [7:0] CTRL_UA   = 8'h07;

	// Input kinds.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Result events.
	localparam logic [1:0] EV_BYTE = 2'd0;
	localparam logic [1:0] EV_OK   = 2'd1;
	localparam logic [1:0] EV_FAIL = 2'd2;

	// Receive phases of the UA recognizer.
	localparam logic [2:0] PH_NONE  = 3'd0;
	localparam logic [2:0] PH_FLAG  = 3'd1;
	localparam logic [2:0] PH_ADDR  = 3'd2;
	localparam logic [2:0] PH_CTRL  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;

	// Jobs handed from the front to the back.
	typedef logic [1:0] job_t;
	localparam job_t JOB_FRAME = 2'd0;
	localparam job_t JOB_OK    = 2'd1;
	localparam job_t JOB_FAIL  = 2'd2;

	// Frame length and byte index.
	localparam int FRAME_LEN = 5;
	localparam int IDX_W     = 3;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

	// Register map and defaults.
	localparam int PADDR_W = 3;
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_TRIES   = 1'b1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd3;
	localparam logic [3:0]  TRIES_RESET   = 4'd3;
	localparam logic [3:0]  TRIES_MAX     = 4'd15;

	// Job queue depth.
	localparam int QUEUE_DEPTH = 4;

	// Push request from front to queue.
	typedef struct packed {
		logic push;
		job_t job;
	} push_req_t;

	// Queue status seen by front and back.
	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// Byte of the SET frame at a given position.
	function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = FLAG_BYTE;
			3'd1: b = ADDR_BYTE;
			3'd2: b = CTRL_SET;
			3'd3: b = ADDR_BYTE ^ CTRL_SET;
			default: b = FLAG_BYTE;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lss_front.sv
// Front part: accepts input words, runs the handshake state and the UA recognizer.
// Issues frame, success and failure jobs to the queue; depends on lss_pkg.
`default_nettype none
module lss_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           kind,
	input  wire logic [7:0]           rx_byte,
	input  wire logic [15:0]          timeout_ticks,
	input  wire logic [3:0]           max_tries,
	input  wire lss_pkg::queue_stat_t qstat,
	output lss_pkg::push_req_t        preq
);

	logic        mode_q;
	logic [2:0]  phase_q;
	logic [7:0]  check_q;
	logic [3:0]  tries_q;
	logic [15:0] ticks_q;

	logic        mode_n;
	logic [2:0]  phase_n;
	logic [7:0]  check_n;
	logic [3:0]  tries_n;
	logic [15:0] ticks_n;
	logic        take;

	// A word is taken whenever the queue has room.
	assign in_ready = !qstat.full;
	assign take     = in_valid && in_ready;

	// Next state and job for the word at the input.
	always_comb begin
		mode_n    = mode_q;
		phase_n   = phase_q;
		check_n   = check_q;
		tries_n   = tries_q;
		ticks_n   = ticks_q;
		preq.push = 1'b0;
		preq.job  = lss_pkg::JOB_FRAME;
		if (take) begin
			if (kind == lss_pkg::KIND_START) begin
				mode_n    = 1'b1;
				tries_n   = '0;
				ticks_n   = timeout_ticks;
				phase_n   = lss_pkg::PH_NONE;
				check_n   = '0;
				preq.push = 1'b1;
				preq.job  = lss_pkg::JOB_FRAME;
			end else if (mode_q && kind == lss_pkg::KIND_BYTE) begin
				case (phase_q)
					lss_pkg::PH_NONE: begin
						if (rx_byte == lss_pkg::FLAG_BYTE) begin
							phase_n = lss_pkg::PH_FLAG;
							check_n = '0;
						end
					end
					lss_pkg::PH_FLAG: begin
						if (rx_byte == lss_pkg::ADDR_BYTE) begin
							phase_n = lss_pkg::PH_ADDR;
							check_n = check_q ^ rx_byte;
						end else if (rx_byte == lss_pkg::FLAG_BYTE) begin
							phase_n = lss_pkg::PH_FLAG;
							check_n = '0;
						end else begin
							phase_n = lss_pkg::PH_NONE;
						end
					end
					lss_pkg::PH_ADDR: begin
						if (rx_byte == lss_pkg::CTRL_UA) begin
							phase_n = lss_pkg::PH_CTRL;
							check_n = check_q ^ rx_byte;
						end else if (rx_byte == lss_pkg::FLAG_BYTE) begin
							phase_n = lss_pkg::PH_FLAG;
							check_n = '0;
						end else begin
							phase_n = lss_pkg::PH_NONE;
						end
					end
					lss_pkg::PH_CTRL: begin
						if (rx_byte == lss_pkg::FLAG_BYTE) begin
							phase_n = lss_pkg::PH_FLAG;
							check_n = '0;
						end else if (rx_byte == check_q) begin
							phase_n = lss_pkg::PH_CHECK;
						end else begin
							phase_n = lss_pkg::PH_NONE;
						end
					end
					lss_pkg::PH_CHECK: begin
						// Closing flag completes the UA frame.
						if (rx_byte == lss_pkg::FLAG_BYTE) begin
							mode_n    = 1'b0;
							phase_n   = lss_pkg::PH_NONE;
							check_n   = '0;
							ticks_n   = '0;
							preq.push = 1'b1;
							preq.job  = lss_pkg::JOB_OK;
						end
					end
					default: begin
						phase_n = lss_pkg::PH_NONE;
					end
				endcase
			end else if (mode_q && kind == lss_pkg::KIND_TICK) begin
				if (ticks_q > 16'd1) begin
					ticks_n = ticks_q - 16'd1;
				end else begin
					// Timeout: count the try, then resend or give up.
					ticks_n = '0;
					if (tries_q < lss_pkg::TRIES_MAX) begin
						tries_n = tries_q + 4'd1;
					end
					phase_n   = lss_pkg::PH_NONE;
					check_n   = '0;
					preq.push = 1'b1;
					if (tries_n >= max_tries) begin
						mode_n   = 1'b0;
						preq.job = lss_pkg::JOB_FAIL;
					end else begin
						ticks_n  = timeout_ticks;
						preq.job = lss_pkg::JOB_FRAME;
					end
				end
			end
		end
	end

	// Handshake state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= lss_pkg::PH_NONE;
			check_q <= '0;
			tries_q <= '0;
			ticks_q <= '0;
		end else begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			check_q <= check_n;
			tries_q <= tries_n;
			ticks_q <= ticks_n;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lss_queue.sv
// Short job queue between the front and the back.
// Register array with read and write pointers; depends on lss_pkg.
`default_nettype none
module lss_queue #(
	parameter int DEPTH = lss_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lss_pkg::push_req_t   preq,
	input  wire logic                 pop,
	output lss_pkg::job_t             head,
	output lss_pkg::queue_stat_t      qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lss_pkg::job_t     mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign do_push     = preq.push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= preq.job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lss_back.sv
// Back part: expands queued jobs into result words, one per cycle while out_ready allows.
// Holds the output register; depends on lss_pkg.
`default_nettype none
module lss_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lss_pkg::job_t        head,
	input  wire lss_pkg::queue_stat_t qstat,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                event_res,
	output logic [7:0]                tx_byte,
	output logic                      last
);

	logic [lss_pkg::IDX_W-1:0] idx_q;
	logic                      valid_q;
	logic [1:0]                event_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      load;
	logic                      take;
	logic [1:0]                ev_n;
	logic [7:0]                byte_n;
	logic                      last_n;

	assign out_valid = valid_q;
	assign event_res = event_q;
	assign tx_byte   = byte_q;
	assign last      = last_q;

	// The output register reloads when empty or being drained.
	assign load = !valid_q || out_ready;
	assign take = load && !qstat.empty;
	assign pop  = take && last_n;

	// Result word for the job at the queue head.
	always_comb begin
		if (head == lss_pkg::JOB_FRAME) begin
			ev_n   = lss_pkg::EV_BYTE;
			byte_n = lss_pkg::frame_byte(idx_q);
			last_n = (idx_q == lss_pkg::IDX_LAST);
		end else begin
			ev_n   = (head == lss_pkg::JOB_OK) ? lss_pkg::EV_OK : lss_pkg::EV_FAIL;
			byte_n = '0;
			last_n = 1'b1;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (take) begin
			event_q <= ev_n;
			byte_q  <= byte_n;
			last_q  <= last_n;
		end
	end

	// Output valid and frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= take;
			end
			if (take) begin
				idx_q <= last_n ? '0 : idx_q + lss_pkg::IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/link_setup_set_ua_handshake.sv
// Sender side of a SET/UA link setup handshake. Input words (start, received
// byte, tick) are taken at one per cycle by the front, which runs the timeout,
// try count and UA recognizer and posts jobs into a queue of QUEUE_DEPTH
// entries. The back turns each job into result words at one per cycle while
// out_ready allows: a SET frame is five words, success or failure one. The job
// is registered in the queue and each result word in the output register; the
// input stalls only while the job queue is full.
// Registers: timeout_ticks at byte address 0, max_tries at byte address 4.
`default_nettype none
`include "link_setup_set_ua_handshake_defines.svh"
module link_setup_set_ua_handshake #(
	parameter int QUEUE_DEPTH = lss_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lss_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  kind,
	input  wire logic [7:0]                  rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       event_res,
	output logic [7:0]                       tx_byte,
	output logic                             last
);

	logic [15:0]          timeout_q;
	logic [3:0]           tries_max_q;
	logic                 cfg_wr;
	lss_pkg::push_req_t   preq;
	lss_pkg::queue_stat_t qstat;
	lss_pkg::job_t        head;
	logic                 pop;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= lss_pkg::TIMEOUT_RESET;
			tries_max_q <= lss_pkg::TRIES_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == lss_pkg::REG_TIMEOUT) begin
				timeout_q <= pwdata[15:0];
			end else begin
				tries_max_q <= pwdata[3:0];
			end
		end
	end

	// Register read back.
	always_comb begin
		if (paddr[2] == lss_pkg::REG_TIMEOUT) begin
			prdata = {16'd0, timeout_q};
		end else begin
			prdata = {28'd0, tries_max_q};
		end
	end

	// Front, job queue and back.
	lss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.rx_byte       (rx_byte),
		.timeout_ticks (timeout_q),
		.max_tries     (tries_max_q),
		.qstat         (qstat),
		.preq          (preq)
	);

	lss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.preq   (preq),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	lss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res),
		.tx_byte   (tx_byte),
		.last      (last)
	);

	// A start always leaves a job in the queue for the back.
	`LSS_ASSERT_NEXT(a_start_queues, clk, arst_n, in_valid && in_ready && kind == lss_pkg::KIND_START, !qstat.empty)
	// Success and failure words are single and so always closing.
	`LSS_ASSERT_SAME(a_event_last, clk, arst_n, out_valid && event_res != lss_pkg::EV_BYTE, last)
	// The closing word of a frame is the flag.
	`LSS_ASSERT_SAME(a_frame_end_flag, clk, arst_n, out_valid && event_res == lss_pkg::EV_BYTE && last, tx_byte == lss_pkg::FLAG_BYTE)

endmodule
`default_nettype wire

### dv/link_setup_set_ua_handshake_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SET/UA link setup handshake block.
// Depends on lss_pkg and the link_setup_set_ua_handshake top level only.
module link_setup_set_ua_handshake_test;

	// The input kind that the block must ignore.
	localparam logic [1:0] KIND_SPARE = 2'd3;
	// Quiet cycles tolerated before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles allowed for words still inside the block after the last result.
	localparam int SETTLE = 8;
	// Random words that the block acts on.
	localparam int RANDOM_WORDS = 85;

	localparam logic [lss_pkg::PADDR_W-1:0] ADDR_TIMEOUT = {lss_pkg::REG_TIMEOUT, 2'b00};
	localparam logic [lss_pkg::PADDR_W-1:0] ADDR_TRIES   = {lss_pkg::REG_TRIES, 2'b00};

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] data;
		logic       fin;
	} result_t;

	typedef enum logic [2:0] {WANT_MODEL, WANT_NONE, WANT_FRAME, WANT_OK, WANT_FAIL} want_t;
	typedef enum logic [0:0] {ROW_WORD, ROW_CONFIG} row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic [1:0]  k;
		logic [7:0]  data;
		want_t       want;
		logic [15:0] timeout;
		logic [3:0]  tries;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [lss_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        kind = lss_pkg::KIND_START;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        event_res;
	logic [7:0]        tx_byte;
	logic              last;

	link_setup_set_ua_handshake u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res),
		.tx_byte   (tx_byte),
		.last      (last)
	);

	always #5 clk = ~clk;

	// Predicted handshake state and register copies.
	logic        ua_waiting = 1'b0;
	logic [2:0]  ua_phase = lss_pkg::PH_NONE;
	logic [7:0]  ua_check = 8'h00;
	logic [3:0]  tries_used = 4'd0;
	logic [15:0] ticks_left = 16'd0;
	logic [15:0] cfg_timeout = lss_pkg::TIMEOUT_RESET;
	logic [3:0]  cfg_tries = lss_pkg::TRIES_RESET;

	result_t   due_words[$];
	result_t   step_words[$];
	plan_row_t plan[$];

	int  bad_words = 0;
	int  live_words = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	int  quiet_cycles = 0;
	int  rx_cycle = 0;

	function automatic result_t mk(logic [1:0] ev, logic [7:0] data, logic fin);
		result_t w;
		w.ev = ev;
		w.data = data;
		w.fin = fin;
		return w;
	endfunction

	// Queue the five SET words and rearm the timer and the UA recognizer.
	task automatic emit_set_frame();
		step_words.push_back(mk(lss_pkg::EV_BYTE, lss_pkg::FLAG_BYTE, 1'b0));
		step_words.push_back(mk(lss_pkg::EV_BYTE, lss_pkg::ADDR_BYTE, 1'b0));
		step_words.push_back(mk(lss_pkg::EV_BYTE, lss_pkg::CTRL_SET, 1'b0));
		step_words.push_back(mk(lss_pkg::EV_BYTE,
			lss_pkg::ADDR_BYTE ^ lss_pkg::CTRL_SET, 1'b0));
		step_words.push_back(mk(lss_pkg::EV_BYTE, lss_pkg::FLAG_BYTE, 1'b1));
		ticks_left = cfg_timeout;
		ua_phase = lss_pkg::PH_NONE;
		ua_check = 8'h00;
	endtask

	// Advance the predicted handshake by one input word, leaving its results in step_words.
	task automatic step_handshake(input logic [1:0] k, input logic [7:0] b);
		step_words.delete();
		if (k == lss_pkg::KIND_START) begin
			ua_waiting = 1'b1;
			tries_used = 4'd0;
			emit_set_frame();
		end else if (ua_waiting && k == lss_pkg::KIND_BYTE) begin
			if (ua_phase == lss_pkg::PH_CHECK) begin
				// Only the closing flag matters once the check byte was good.
				if (b == lss_pkg::FLAG_BYTE) begin
					ua_waiting = 1'b0;
					ua_phase = lss_pkg::PH_NONE;
					ua_check = 8'h00;
					ticks_left = 16'd0;
					step_words.push_back(mk(lss_pkg::EV_OK, 8'h00, 1'b1));
				end
			end else if (b == lss_pkg::FLAG_BYTE) begin
				// Any flag before the check byte opens a new frame.
				ua_phase = lss_pkg::PH_FLAG;
				ua_check = 8'h00;
			end else begin
				case (ua_phase)
					lss_pkg::PH_FLAG: begin
						if (b == lss_pkg::ADDR_BYTE) begin
							ua_phase = lss_pkg::PH_ADDR;
							ua_check ^= b;
						end else begin
							ua_phase = lss_pkg::PH_NONE;
						end
					end
					lss_pkg::PH_ADDR: begin
						if (b == lss_pkg::CTRL_UA) begin
							ua_phase = lss_pkg::PH_CTRL;
							ua_check ^= b;
						end else begin
							ua_phase = lss_pkg::PH_NONE;
						end
					end
					lss_pkg::PH_CTRL: begin
						ua_phase = (b == ua_check) ? lss_pkg::PH_CHECK : lss_pkg::PH_NONE;
					end
					default: begin
						ua_phase = lss_pkg::PH_NONE;
					end
				endcase
			end
		end else if (ua_waiting && k == lss_pkg::KIND_TICK) begin
			if (ticks_left > 16'd1) begin
				ticks_left = ticks_left - 16'd1;
			end else begin
				// Timeout: count the try, then resend or give up.
				ticks_left = 16'd0;
				if (tries_used < lss_pkg::TRIES_MAX)
					tries_used = tries_used + 4'd1;
				if (tries_used >= cfg_tries) begin
					ua_waiting = 1'b0;
					ua_phase = lss_pkg::PH_NONE;
					ua_check = 8'h00;
					step_words.push_back(mk(lss_pkg::EV_FAIL, 8'h00, 1'b1));
				end else begin
					emit_set_frame();
				end
			end
		end
	endtask

	// Offer one input word, wait for its acceptance and record what it should produce.
	task automatic push_word(input logic [1:0] k, input logic [7:0] b, input want_t want);
		bit live;
		live = (k == lss_pkg::KIND_START) || (ua_waiting && k != KIND_SPARE);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		step_handshake(k, b);
		case (want)
			WANT_MODEL: begin
				foreach (step_words[i])
					due_words.push_back(step_words[i]);
			end
			WANT_FRAME: begin
				due_words.push_back(mk(lss_pkg::EV_BYTE, 8'h7E, 1'b0));
				due_words.push_back(mk(lss_pkg::EV_BYTE, 8'h03, 1'b0));
				due_words.push_back(mk(lss_pkg::EV_BYTE, 8'h03, 1'b0));
				due_words.push_back(mk(lss_pkg::EV_BYTE, 8'h00, 1'b0));
				due_words.push_back(mk(lss_pkg::EV_BYTE, 8'h7E, 1'b1));
			end
			WANT_OK: due_words.push_back(mk(lss_pkg::EV_OK, 8'h00, 1'b1));
			WANT_FAIL: due_words.push_back(mk(lss_pkg::EV_FAIL, 8'h00, 1'b1));
			default: ;
		endcase
		if (live)
			live_words++;
	endtask

	// Hold the input until every due word has come out and the block has settled.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lss_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [lss_pkg::PADDR_W-1:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d read, expected %0h, got %0h", $time, addr, want, prdata);
			bad_words++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram both registers once the block is idle, then read them back.
	task automatic set_config(input logic [15:0] t, input logic [3:0] m);
		drain_results();
		write_reg(ADDR_TIMEOUT, {16'h0000, t});
		write_reg(ADDR_TRIES, {28'h0000000, m});
		cfg_timeout = t;
		cfg_tries = m;
		read_reg(ADDR_TIMEOUT, {16'h0000, t});
		read_reg(ADDR_TRIES, {28'h0000000, m});
	endtask

	task automatic add_word(input logic [1:0] k, input logic [7:0] b, input want_t want);
		plan_row_t r;
		r = '0;
		r.op = ROW_WORD;
		r.k = k;
		r.data = b;
		r.want = want;
		plan.push_back(r);
	endtask

	task automatic add_config(input logic [15:0] t, input logic [3:0] m);
		plan_row_t r;
		r = '0;
		r.op = ROW_CONFIG;
		r.timeout = t;
		r.tries = m;
		plan.push_back(r);
	endtask

	// One random exchange, mostly well-formed UA frames and ticks while a handshake runs.
	task automatic random_exchange();
		int         r;
		int         bad;
		int         tick_at;
		bit         extra;
		logic [7:0] b;
		logic [7:0] junk;
		logic [7:0] ua[5];
		ua[0] = lss_pkg::FLAG_BYTE;
		ua[1] = lss_pkg::ADDR_BYTE;
		ua[2] = lss_pkg::CTRL_UA;
		ua[3] = lss_pkg::ADDR_BYTE ^ lss_pkg::CTRL_UA;
		ua[4] = lss_pkg::FLAG_BYTE;
		r = $urandom_range(0, 99);
		junk = 8'($urandom_range(0, 255));
		if (!ua_waiting) begin
			if (r < 75)
				push_word(lss_pkg::KIND_START, junk, WANT_MODEL);
			else if (r < 85)
				push_word(lss_pkg::KIND_TICK, junk, WANT_MODEL);
			else if (r < 93)
				push_word(lss_pkg::KIND_BYTE, junk, WANT_MODEL);
			else
				push_word(KIND_SPARE, junk, WANT_MODEL);
		end else if (r < 8) begin
			push_word(lss_pkg::KIND_START, junk, WANT_MODEL);
		end else if (r < 50) begin
			// A UA frame, sometimes with a bad byte, a stray byte or a tick inside.
			bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 5;
			tick_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4) : 5;
			extra = ($urandom_range(0, 6) == 0);
			for (int i = 0; i < 5; i++) begin
				if (i == 4 && extra)
					push_word(lss_pkg::KIND_BYTE, 8'($urandom_range(0, 255)), WANT_MODEL);
				b = (i == bad) ? 8'($urandom_range(0, 255)) : ua[i];
				push_word(lss_pkg::KIND_BYTE, b, WANT_MODEL);
				if (i == tick_at)
					push_word(lss_pkg::KIND_TICK, junk, WANT_MODEL);
			end
		end else if (r < 75) begin
			repeat ($urandom_range(1, 3))
				push_word(lss_pkg::KIND_TICK, 8'($urandom_range(0, 255)), WANT_MODEL);
		end else if (r < 92) begin
			push_word(lss_pkg::KIND_BYTE, junk, WANT_MODEL);
		end else begin
			push_word(KIND_SPARE, junk, WANT_MODEL);
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			bad_words++;
		end
	endtask

	// Result checker: every accepted word is matched against the oldest due word.
	always @(posedge clk) begin
		result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got event %0h byte %0h last %0h",
					$time, event_res, tx_byte, last);
				bad_words++;
			end else begin
				w = due_words.pop_front();
				compare_field("event_res", w.ev, event_res);
				compare_field("tx_byte", w.data, tx_byte);
				compare_field("last", w.fin, last);
			end
		end
	end

	// Receiver backpressure: always ready, then random stalls, then a fixed pattern.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 160) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ((rx_cycle % 7) < 4);
		endcase
	end

	// Watchdog on cycles in which nothing moves on any port.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int  next_cfg;
		bit  paused;
		// Directed rows: idle words, UA recognizer corners, timeouts and register extremes.
		add_word(lss_pkg::KIND_TICK, 8'h00, WANT_NONE);
		add_word(lss_pkg::KIND_BYTE, 8'h7E, WANT_NONE);
		add_word(KIND_SPARE, 8'hFF, WANT_NONE);
		add_word(lss_pkg::KIND_START, 8'hFF, WANT_FRAME);
		add_word(lss_pkg::KIND_BYTE, 8'h7E, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h03, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h7E, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h03, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h07, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'hFF, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h7E, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h03, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h07, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h04, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h00, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h7E, WANT_OK);
		add_config(16'd1, 4'd2);
		add_word(lss_pkg::KIND_START, 8'h00, WANT_FRAME);
		add_word(KIND_SPARE, 8'h00, WANT_NONE);
		add_word(lss_pkg::KIND_TICK, 8'hFF, WANT_MODEL);
		add_word(lss_pkg::KIND_START, 8'h00, WANT_FRAME);
		add_word(lss_pkg::KIND_TICK, 8'h00, WANT_MODEL);
		add_word(lss_pkg::KIND_TICK, 8'h00, WANT_FAIL);
		add_config(16'd0, 4'd0);
		add_word(lss_pkg::KIND_START, 8'h00, WANT_FRAME);
		add_word(lss_pkg::KIND_TICK, 8'h00, WANT_FAIL);
		add_config(16'hFFFF, 4'd15);
		add_word(lss_pkg::KIND_START, 8'h00, WANT_FRAME);
		add_word(lss_pkg::KIND_TICK, 8'h00, WANT_MODEL);
		add_word(lss_pkg::KIND_BYTE, 8'h7E, WANT_MODEL);

		// Reset, then confirm the register defaults.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_reg(ADDR_TIMEOUT, {16'h0000, lss_pkg::TIMEOUT_RESET});
		read_reg(ADDR_TRIES, {28'h0000000, lss_pkg::TRIES_RESET});

		foreach (plan[i]) begin
			if (plan[i].op == ROW_CONFIG)
				set_config(plan[i].timeout, plan[i].tries);
			else
				push_word(plan[i].k, plan[i].data, plan[i].want);
		end

		// Random part in phases, each with its own register setting.
		live_words = 0;
		next_cfg = 0;
		paused = 1'b0;
		while (live_words < RANDOM_WORDS) begin
			if (live_words >= next_cfg) begin
				case ($urandom_range(0, 9))
					0: set_config(16'd1, 4'($urandom_range(1, 4)));
					1: set_config(16'hFFFF, 4'd15);
					2: set_config(16'd0, 4'd0);
					3: set_config(16'($urandom_range(1, 6)), 4'd15);
					default: set_config(16'($urandom_range(1, 6)), 4'($urandom_range(1, 4)));
				endcase
				gaps_on = ($urandom_range(0, 2) != 0);
				next_cfg += $urandom_range(20, 40);
			end
			if (!paused && live_words >= RANDOM_WORDS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			random_exchange();
		end

		drain_results();
		if (bad_words == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
